### src/bstk_pkg.sv
// shared types and constants for the bounded stack
package bstk_pkg;

  localparam int POS_W  = 7;
  localparam int WORD_W = 32;
  localparam int CAP_W  = 7;
  localparam int ADDR_W = 3;

  // request kinds
  localparam logic [2:0] REQ_PUSH   = 3'd0;
  localparam logic [2:0] REQ_POP    = 3'd1;
  localparam logic [2:0] REQ_DUMP   = 3'd2;
  localparam logic [2:0] REQ_UPDATE = 3'd3;
  localparam logic [2:0] REQ_PEEK   = 3'd4;
  localparam logic [2:0] REQ_PEEP   = 3'd5;

  // result status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_OVERFLOW = 2'd1;
  localparam logic [1:0] STS_EMPTY    = 2'd2;
  localparam logic [1:0] STS_BADPOS   = 2'd3;

  // register map
  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 3'd0;
  localparam logic [CAP_W-1:0]  CAP_RESET     = 7'd64;

  typedef struct packed {
    logic [2:0]              req_type;
    logic [POS_W-1:0]        position;
    logic signed [WORD_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [WORD_W-1:0] data;
    logic [POS_W-1:0]        depth_now;
    logic                    last;
  } out_beat_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             rotate;
    logic             wr;
    logic [POS_W-1:0] wr_slot;
    logic [POS_W-1:0] ring_end;
  } cell_ctl_t;

endpackage

### src/bstk_cell.sv
// one storage cell of the stack chain; cell 0 is the top of stack
module bstk_cell
  import bstk_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [WORD_W-1:0] above,
  input  logic signed [WORD_W-1:0] below,
  input  logic signed [WORD_W-1:0] wrap,
  input  logic signed [WORD_W-1:0] upd_value,
  output logic signed [WORD_W-1:0] word
);

  localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

  logic signed [WORD_W-1:0] word_r;

  // push shifts down, pop shifts up, rotate moves up with the deepest live cell
  // taking the old top
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      word_r <= above;
    end else if (ctl.pop) begin
      word_r <= below;
    end else if (ctl.rotate) begin
      word_r <= (ctl.ring_end == IDX) ? wrap : below;
    end else if (ctl.wr && (ctl.wr_slot == IDX)) begin
      word_r <= upd_value;
    end
  end

  assign word = word_r;

endmodule

### src/bstk_ctrl.sv
// request sequencer, entry count and result register of the stack
module bstk_ctrl
  import bstk_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_beat_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_beat_t                out_data,
  input  logic [CAP_W-1:0]         usable_cap,
  input  logic signed [WORD_W-1:0] top_word,
  output cell_ctl_t                ctl
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [POS_W-1:0] DEPTH_P = POS_W'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic [CW-1:0] target_r, target_nxt;
  logic          dump_r, dump_nxt;
  logic          out_valid_r;
  out_beat_t     out_r, out_nxt;
  logic          load_out;

  logic             can_load;
  logic             accept;
  logic [POS_W-1:0] count_p;
  logic             pos_ok;
  logic             is_empty;
  logic             is_full;
  logic [POS_W-1:0] pos_m1;
  logic [CW-1:0]    count_m1;

  function automatic out_beat_t mk_beat(input logic [1:0] sts,
                                        input logic signed [WORD_W-1:0] d,
                                        input logic [POS_W-1:0] dep,
                                        input logic lst);
    out_beat_t b;
    b.status    = sts;
    b.data      = d;
    b.depth_now = dep;
    b.last      = lst;
    return b;
  endfunction

  assign can_load = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && can_load;
  assign accept   = in_valid && in_ready;
  assign count_p  = POS_W'(count_r);
  assign count_m1 = count_r - CW'(1);
  assign pos_m1   = in_data.position - POS_W'(1);
  assign pos_ok   = (in_data.position != '0) && (in_data.position <= count_p);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_p >= usable_cap) || (count_p >= DEPTH_P);

  // request decode and walk sequencing
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    step_nxt     = step_r;
    target_nxt   = target_r;
    dump_nxt     = dump_r;
    out_nxt      = out_r;
    load_out     = 1'b0;
    ctl          = '0;
    ctl.ring_end = count_p - POS_W'(1);
    ctl.wr_slot  = pos_m1;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.req_type)
            REQ_PUSH: begin
              load_out = 1'b1;
              if (is_full) begin
                out_nxt = mk_beat(STS_OVERFLOW, '0, count_p, 1'b1);
              end else begin
                ctl.push  = 1'b1;
                count_nxt = count_r + CW'(1);
                out_nxt   = mk_beat(STS_OK, '0, count_p + POS_W'(1), 1'b1);
              end
            end
            REQ_POP: begin
              load_out = 1'b1;
              if (is_empty) begin
                out_nxt = mk_beat(STS_EMPTY, '0, count_p, 1'b1);
              end else begin
                ctl.pop   = 1'b1;
                count_nxt = count_m1;
                out_nxt   = mk_beat(STS_OK, top_word, count_p - POS_W'(1), 1'b1);
              end
            end
            REQ_DUMP: begin
              if (is_empty) begin
                load_out = 1'b1;
                out_nxt  = mk_beat(STS_EMPTY, '0, count_p, 1'b1);
              end else begin
                state_nxt = ST_WALK;
                step_nxt  = '0;
                dump_nxt  = 1'b1;
              end
            end
            REQ_UPDATE: begin
              load_out = 1'b1;
              if (pos_ok) begin
                ctl.wr  = 1'b1;
                out_nxt = mk_beat(STS_OK, '0, count_p, 1'b1);
              end else begin
                out_nxt = mk_beat(STS_BADPOS, '0, count_p, 1'b1);
              end
            end
            REQ_PEEK: begin
              load_out = 1'b1;
              if (is_empty) begin
                out_nxt = mk_beat(STS_EMPTY, '0, count_p, 1'b1);
              end else begin
                out_nxt = mk_beat(STS_OK, top_word, count_p, 1'b1);
              end
            end
            REQ_PEEP: begin
              if (pos_ok) begin
                state_nxt  = ST_WALK;
                step_nxt   = '0;
                dump_nxt   = 1'b0;
                target_nxt = pos_m1[CW-1:0];
              end else begin
                load_out = 1'b1;
                out_nxt  = mk_beat(STS_BADPOS, '0, count_p, 1'b1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        // one rotation per cycle while can_load; count steps restore the ring
        if (can_load) begin
          ctl.rotate = 1'b1;
          if (dump_r) begin
            load_out = 1'b1;
            out_nxt  = mk_beat(STS_OK, top_word, count_p, step_r == count_m1);
          end else if (step_r == target_r) begin
            load_out = 1'b1;
            out_nxt  = mk_beat(STS_OK, top_word, count_p, 1'b1);
          end
          step_nxt = step_r + CW'(1);
          if (step_r == count_m1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      target_r    <= '0;
      dump_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      step_r   <= step_nxt;
      target_r <= target_nxt;
      dump_r   <= dump_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### src/bounded_stack_with_peep_update.sv
// Bounded LIFO stack of signed 32-bit words held in a chain of DEPTH cells, cell 0
// being the top. Push, pop, peek and update are handled in the idle state when
// accepted: push shifts the chain down, pop shifts it up, update writes the
// addressed cell in place. Dump and peep rotate the live part of the chain up by
// one cell per cycle while the result register can load, so that each entry
// passes through the top cell; after one rotation per entry the stack is back in
// its original order, and a stalled result register holds the rotation.
// The usable capacity comes from the capacity register (address 0, reset 64,
// saturated to DEPTH). Reset clears the entry count but not the cells; no
// clearing pass is run.
module bounded_stack_with_peep_update
  import bstk_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_beat_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [CAP_W-1:0] DEPTH_C = CAP_W'(DEPTH);

  logic [CAP_W-1:0]         capacity_r;
  logic [CAP_W-1:0]         usable_cap;
  cell_ctl_t                ctl;
  logic signed [WORD_W-1:0] cell_word [DEPTH];

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_CAPACITY)) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  assign pready     = 1'b1;
  assign prdata     = (paddr == ADDR_CAPACITY) ? {{(32-CAP_W){1'b0}}, capacity_r} : '0;
  assign usable_cap = (capacity_r > DEPTH_C) ? DEPTH_C : capacity_r;

  bstk_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .usable_cap(usable_cap),
    .top_word  (cell_word[0]),
    .ctl       (ctl)
  );

  // chain of cells, each linked to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] above_w;
    logic signed [WORD_W-1:0] below_w;

    if (i == 0) begin : g_top
      assign above_w = in_data.value;
    end else begin : g_mid
      assign above_w = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      assign below_w = '0;
    end else begin : g_up
      assign below_w = cell_word[i+1];
    end

    bstk_cell #(
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .above    (above_w),
      .below    (below_w),
      .wrap     (cell_word[0]),
      .upd_value(in_data.value),
      .word     (cell_word[i])
    );
  end

endmodule
